/* design/fdpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpi_pkg
// Shared types, constants and single-precision helper functions for the
// interleaved float dot-product block.
// ----------------------------------------------------------------------------
package fdpi_pkg;

  // Lanes carried by one input beat (fixed by the port list)
  localparam int unsigned Lanes = 4;
  localparam int unsigned LaneW = (Lanes > 1) ? $clog2(Lanes) : 1;

  localparam logic [31:0] QnanDefault = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit    = 32'h0040_0000;

  typedef logic [31:0] f32_t;

  // Leading-zero count of a 48-bit product
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd0;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n   = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // Leading-zero count of a 27-bit significand
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n   = 5'(26 - i);
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. m has the hidden bit at 26 and
  // guard/round/sticky in [2:0]; e is the biased exponent of that bit.
  function automatic f32_t round_pack(input logic s, input logic signed [10:0] e,
                                      input logic [26:0] m);
    logic [26:0]        mm;
    logic signed [10:0] ee;
    logic [10:0]        shw;
    logic [4:0]         sh;
    logic               inc;
    logic [24:0]        mr;
    logic [7:0]         ef;
    logic [22:0]        fr;
    mm = m;
    ee = e;
    // Denormal range: shift right, keep sticky
    if (e < 11'sd1) begin
      shw = 11'(11'sd1 - e);
      sh  = (shw > 11'd26) ? 5'd27 : shw[4:0];
      mm  = (m >> sh) | {26'b0, |(m & ~({27{1'b1}} << sh))};
      ee  = 11'sd1;
    end
    inc = mm[2] & (mm[1] | mm[0] | mm[3]);
    mr  = {1'b0, mm[26:3]} + 25'(inc);
    if (mr[24]) begin
      ee = ee + 11'sd1;
      ef = ee[7:0];
      fr = mr[23:1];
    end else if (mr[23]) begin
      ef = ee[7:0];
      fr = mr[22:0];
    end else begin
      ef = 8'd0;
      fr = mr[22:0];
    end
    if (ee > 11'sd254) begin
      return {s, 8'hFF, 23'd0};
    end
    return {s, ef, fr};
  endfunction

endpackage

/* design/fdpi_fadd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpi_fadd
// Two-stage single-precision adder, z = x + y, round to nearest even.
// Stage 1 aligns and adds, stage 2 normalizes and rounds.
// ----------------------------------------------------------------------------
module fdpi_fadd (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fdpi_pkg::f32_t     x_i,
  input  fdpi_pkg::f32_t     y_i,
  output logic               out_valid_o,
  output fdpi_pkg::f32_t     z_o
);

  logic               v1_q, v2_q;
  logic               spec_d, spec_q;
  fdpi_pkg::f32_t     sval_d, sval_q;
  logic               sgn_d, sgn_q;
  logic               zsgn_d, zsgn_q;
  logic signed [10:0] exp_d, exp_q;
  logic [27:0]        sum_d, sum_q;
  fdpi_pkg::f32_t     z_d, z_q;

  // Stage 1: specials, alignment, add
  always_comb begin
    logic [7:0]  ex, ey, eb, es;
    logic [23:0] mx, my, mb, ms;
    logic        xnan, ynan, xinf, yinf, xbig;
    logic [7:0]  dd;
    logic [4:0]  sh;
    logic [26:0] sm, al;
    ex   = x_i[30:23];
    ey   = y_i[30:23];
    mx   = {(ex != 8'd0), x_i[22:0]};
    my   = {(ey != 8'd0), y_i[22:0]};
    xnan = (ex == 8'hFF) && (x_i[22:0] != 23'd0);
    ynan = (ey == 8'hFF) && (y_i[22:0] != 23'd0);
    xinf = (ex == 8'hFF) && (x_i[22:0] == 23'd0);
    yinf = (ey == 8'hFF) && (y_i[22:0] == 23'd0);
    spec_d = 1'b1;
    sval_d = x_i;
    priority if (xnan) sval_d = x_i | fdpi_pkg::QuietBit;
    else if (ynan) sval_d = y_i | fdpi_pkg::QuietBit;
    else if (xinf && yinf && (x_i[31] != y_i[31])) sval_d = fdpi_pkg::QnanDefault;
    else if (xinf) sval_d = x_i;
    else if (yinf) sval_d = y_i;
    else spec_d = 1'b0;
    if (ex == 8'd0) ex = 8'd1;
    if (ey == 8'd0) ey = 8'd1;
    xbig  = (ex > ey) || ((ex == ey) && (mx >= my));
    eb    = xbig ? ex : ey;
    es    = xbig ? ey : ex;
    mb    = xbig ? mx : my;
    ms    = xbig ? my : mx;
    sgn_d = xbig ? x_i[31] : y_i[31];
    dd    = eb - es;
    sh    = (dd > 8'd26) ? 5'd27 : dd[4:0];
    sm    = {ms, 3'b000};
    al    = (sm >> sh) | {26'b0, |(sm & ~({27{1'b1}} << sh))};
    if (x_i[31] == y_i[31]) sum_d = {1'b0, mb, 3'b000} + {1'b0, al};
    else                    sum_d = {1'b0, mb, 3'b000} - {1'b0, al};
    zsgn_d = x_i[31] & y_i[31];
    exp_d  = 11'(eb);
  end

  // Stage 2: normalize and round
  always_comb begin
    logic [4:0]  lz;
    logic [26:0] m;
    m  = sum_q[26:0];
    lz = fdpi_pkg::lzc27(sum_q[26:0]);
    priority if (spec_q) z_d = sval_q;
    else if (sum_q == 28'd0) z_d = {zsgn_q, 31'd0};
    else if (sum_q[27]) begin
      m   = {sum_q[27:2], sum_q[1] | sum_q[0]};
      z_d = fdpi_pkg::round_pack(sgn_q, exp_q + 11'sd1, m);
    end else begin
      m   = sum_q[26:0] << lz;
      z_d = fdpi_pkg::round_pack(sgn_q, exp_q - 11'(lz), m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    spec_q <= spec_d;
    sval_q <= sval_d;
    sgn_q  <= sgn_d;
    zsgn_q <= zsgn_d;
    exp_q  <= exp_d;
    sum_q  <= sum_d;
    z_q    <= z_d;
  end

  assign out_valid_o = v2_q;
  assign z_o         = z_q;

endmodule

/* design/fdpi_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpi_lane
// One lane: two-stage float multiplier feeding the adder, with BINS
// accumulators addressed by the bin select.
// ----------------------------------------------------------------------------
module fdpi_lane #(
  parameter int unsigned BINS = 4,
  parameter int unsigned BinW = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fdpi_pkg::f32_t      a_i,
  input  fdpi_pkg::f32_t      b_i,
  input  logic [BinW-1:0]     bin_i,
  input  logic                clr_i,
  output fdpi_pkg::f32_t      acc_o,
  output logic                done_o
);

  logic               v1_q, v2_q;
  logic               spec_d, spec_q;
  fdpi_pkg::f32_t     sval_d, sval_q;
  logic               sgn_d, sgn_q;
  logic signed [10:0] esum_d, esum_q;
  logic [47:0]        prod_d, prod_q;
  fdpi_pkg::f32_t     p_d, p_q;
  fdpi_pkg::f32_t     acc_q [BINS];
  logic               add_v;
  fdpi_pkg::f32_t     add_z;

  // Multiply stage 1: specials and significand product
  always_comb begin
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        anan, bnan, ainf, binf, azero, bzero;
    ea    = a_i[30:23];
    eb    = b_i[30:23];
    ma    = {(ea != 8'd0), a_i[22:0]};
    mb    = {(eb != 8'd0), b_i[22:0]};
    anan  = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    bnan  = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
    ainf  = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
    binf  = (eb == 8'hFF) && (b_i[22:0] == 23'd0);
    azero = (a_i[30:0] == 31'd0);
    bzero = (b_i[30:0] == 31'd0);
    sgn_d  = a_i[31] ^ b_i[31];
    spec_d = 1'b1;
    sval_d = {sgn_d, 8'hFF, 23'd0};
    priority if (anan) sval_d = a_i | fdpi_pkg::QuietBit;
    else if (bnan) sval_d = b_i | fdpi_pkg::QuietBit;
    else if ((ainf && bzero) || (binf && azero)) sval_d = fdpi_pkg::QnanDefault;
    else if (ainf || binf) sval_d = {sgn_d, 8'hFF, 23'd0};
    else spec_d = 1'b0;
    if (ea == 8'd0) ea = 8'd1;
    if (eb == 8'd0) eb = 8'd1;
    esum_d = 11'(ea) + 11'(eb) - 11'sd126;
    prod_d = ma * mb;
  end

  // Multiply stage 2: normalize and round the product
  always_comb begin
    logic [5:0]  lz;
    logic [47:0] pn;
    lz = fdpi_pkg::lzc48(prod_q);
    pn = prod_q << lz;
    priority if (spec_q) p_d = sval_q;
    else if (prod_q == 48'd0) p_d = {sgn_q, 31'd0};
    else p_d = fdpi_pkg::round_pack(sgn_q, esum_q - 11'(lz), {pn[47:22], |pn[21:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    spec_q <= spec_d;
    sval_q <= sval_d;
    sgn_q  <= sgn_d;
    esum_q <= esum_d;
    prod_q <= prod_d;
    p_q    <= p_d;
  end

  // Accumulate into the selected bin
  fdpi_fadd u_add (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .x_i         (acc_q[bin_i]),
    .y_i         (p_q),
    .out_valid_o (add_v),
    .z_o         (add_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BINS; i++) acc_q[i] <= '0;
    end else if (clr_i) begin
      for (int i = 0; i < BINS; i++) acc_q[i] <= '0;
    end else if (add_v) begin
      acc_q[bin_i] <= add_z;
    end
  end

  assign acc_o  = acc_q[bin_i];
  assign done_o = add_v;

endmodule

/* design/fdpi_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdpi_merge
// Sums all lane accumulators from +0.0, bin 0 upward and lane 0 upward
// within a bin, through one shared adder.
// ----------------------------------------------------------------------------
module fdpi_merge #(
  parameter int unsigned BINS = 4,
  parameter int unsigned BinW = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fdpi_pkg::f32_t      acc_i [fdpi_pkg::Lanes],
  output logic [BinW-1:0]     bin_o,
  output logic                done_o,
  output fdpi_pkg::f32_t      sum_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_ISSUE,
    M_WAIT
  } mstate_e;

  mstate_e                    state_q;
  logic [BinW-1:0]            bin_q;
  logic [fdpi_pkg::LaneW-1:0] lane_q;
  fdpi_pkg::f32_t             tot_q;
  logic                       done_q;
  logic                       add_v;
  fdpi_pkg::f32_t             add_z;

  fdpi_fadd u_add (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (state_q == M_ISSUE),
    .x_i         (tot_q),
    .y_i         (acc_i[lane_q]),
    .out_valid_o (add_v),
    .z_o         (add_z)
  );

  // Walk bins and lanes, one dependent add at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      bin_q   <= '0;
      lane_q  <= '0;
      tot_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q <= M_ISSUE;
            bin_q   <= '0;
            lane_q  <= '0;
            tot_q   <= '0;
          end
        end
        M_ISSUE: state_q <= M_WAIT;
        M_WAIT: begin
          if (add_v) begin
            tot_q <= add_z;
            if (lane_q == fdpi_pkg::LaneW'(fdpi_pkg::Lanes - 1)) begin
              lane_q <= '0;
              if (bin_q == BinW'(BINS - 1)) begin
                state_q <= M_IDLE;
                done_q  <= 1'b1;
              end else begin
                bin_q   <= bin_q + 1'b1;
                state_q <= M_ISSUE;
              end
            end else begin
              lane_q  <= lane_q + 1'b1;
              state_q <= M_ISSUE;
            end
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign bin_o  = bin_q;
  assign done_o = done_q;
  assign sum_o  = tot_q;

endmodule

/* design/float_dot_product_interleaved.sv */
`timescale 1ns / 1ps
// Flow: a beat passes through its lane's multiplier and adder, then is written to
// its bin. A last beat then runs the merge (one dependent 2-stage add per
// accumulator); the sum is captured, then moved to the output register once it is free.
// A new beat is stalled until the previous beat's accumulate has been written.
// Reset clears all accumulators to +0.0, the bin counter and all valid state.
// ----------------------------------------------------------------------------
// float_dot_product_interleaved
// Four-lane single-precision dot product with BINS interleaved accumulator
// bins per lane and an ordered merge on the last beat.
// ----------------------------------------------------------------------------
module float_dot_product_interleaved #(
  parameter int unsigned BINS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a_lane0_i,
  input  logic [31:0] a_lane1_i,
  input  logic [31:0] a_lane2_i,
  input  logic [31:0] a_lane3_i,
  input  logic [31:0] b_lane0_i,
  input  logic [31:0] b_lane1_i,
  input  logic [31:0] b_lane2_i,
  input  logic [31:0] b_lane3_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] dot_value_o
);

  localparam int unsigned BinW = (BINS > 1) ? $clog2(BINS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_MERGE,
    S_HOLD
  } state_e;

  state_e          state_q;
  logic [BinW-1:0] bin_q;
  logic            last_q;
  logic            out_valid_q;
  logic [31:0]     dot_q;
  logic            fire;
  logic            clr;
  logic            merge_go;
  logic [BinW-1:0] merge_bin;
  logic            merge_done;
  fdpi_pkg::f32_t  merge_sum;
  fdpi_pkg::f32_t  res_q;
  logic [BinW-1:0] lane_bin;
  logic            out_free;

  fdpi_pkg::f32_t  a_vec [fdpi_pkg::Lanes];
  fdpi_pkg::f32_t  b_vec [fdpi_pkg::Lanes];
  fdpi_pkg::f32_t  acc_vec [fdpi_pkg::Lanes];
  logic [fdpi_pkg::Lanes-1:0] done_vec;

  assign a_vec[0] = a_lane0_i;
  assign a_vec[1] = a_lane1_i;
  assign a_vec[2] = a_lane2_i;
  assign a_vec[3] = a_lane3_i;
  assign b_vec[0] = b_lane0_i;
  assign b_vec[1] = b_lane1_i;
  assign b_vec[2] = b_lane2_i;
  assign b_vec[3] = b_lane3_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign fire       = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr        = (state_q == S_HOLD) && out_free;
  assign merge_go   = (state_q == S_ACC) && done_vec[0] && last_q;
  assign lane_bin   = (state_q == S_MERGE) ? merge_bin : bin_q;

  // Lanes
  for (genvar g = 0; g < fdpi_pkg::Lanes; g++) begin : g_lane
    fdpi_lane #(
      .BINS (BINS),
      .BinW (BinW)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (fire),
      .a_i     (a_vec[g]),
      .b_i     (b_vec[g]),
      .bin_i   (lane_bin),
      .clr_i   (clr),
      .acc_o   (acc_vec[g]),
      .done_o  (done_vec[g])
    );
  end

  fdpi_merge #(
    .BINS (BINS),
    .BinW (BinW)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_go),
    .acc_i   (acc_vec),
    .bin_o   (merge_bin),
    .done_o  (merge_done),
    .sum_o   (merge_sum)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      dot_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (fire) begin
            last_q  <= last_item_i;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (done_vec[0]) begin
            bin_q   <= (bin_q == BinW'(BINS - 1)) ? '0 : bin_q + 1'b1;
            state_q <= last_q ? S_MERGE : S_IDLE;
          end
        end
        S_MERGE: begin
          if (merge_done) begin
            res_q   <= merge_sum;
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            dot_q       <= res_q;
            out_valid_q <= 1'b1;
            bin_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_value_o = dot_q;

endmodule
